[src/hfa_pkg.sv]
// ----------------------------------------------------------------------------
// hfa_pkg
// Shared constants, codes and types of the hole fit allocator.
// ----------------------------------------------------------------------------
package hfa_pkg;

  localparam int MAX_HOLES = 32;
  localparam int SIZE_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_HOLES);
  localparam int CNT_W     = $clog2(MAX_HOLES + 1);
  localparam int TOTAL_W   = 21;
  localparam int APB_AW    = 2;
  localparam int APB_DW    = 32;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_PLACE   = 2'd1,
    REQ_RESTART = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  typedef enum logic [2:0] {
    STAT_PLACED  = 3'd0,
    STAT_NO_FIT  = 3'd1,
    STAT_STORED  = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_RESTART = 3'd4
  } status_e;

  // One hole read back from the table, presented to the selector
  typedef struct packed {
    logic                 clr;
    logic                 vld;
    logic                 free;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
  } scan_ctl_t;

  // Current choice of the selector
  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
  } pick_t;

endpackage

[src/hfa_apb_regs.sv]
// ----------------------------------------------------------------------------
// hfa_apb_regs
// APB register slave holding the placement policy.
// ----------------------------------------------------------------------------
module hfa_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hfa_pkg::APB_AW-1:0]   paddr,
  input  logic [hfa_pkg::APB_DW-1:0]   pwdata,
  output logic [hfa_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output logic [1:0]                   fit_mode_o
);
  import hfa_pkg::*;

  logic [1:0] fit_mode_q, fit_mode_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    fit_mode_d = fit_mode_q;
    if (wr_en) begin
      fit_mode_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= FIT_FIRST;
    end else begin
      fit_mode_q <= fit_mode_d;
    end
  end

  // Only the policy register lives in the word at offset zero
  assign prdata     = (paddr == '0) ? {{(APB_DW-2){1'b0}}, fit_mode_q} : '0;
  assign fit_mode_o = fit_mode_q;

endmodule

[src/hfa_picker.sv]
// ----------------------------------------------------------------------------
// hfa_picker
// Running hole selection: folds in one table entry per cycle under the
// chosen fit policy and keeps the current best candidate.
// ----------------------------------------------------------------------------
module hfa_picker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [1:0]                     fit_mode_i,
  input  logic [hfa_pkg::SIZE_BITS-1:0]  req_size_i,
  input  hfa_pkg::scan_ctl_t             ctl_i,
  output hfa_pkg::pick_t                 pick_o
);
  import hfa_pkg::*;

  logic                 found_q, found_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic                 hit;
  logic                 fits;
  logic                 take;

  assign hit  = ctl_i.vld && ctl_i.free;
  assign fits = ctl_i.size >= req_size_i;

  always_comb begin
    unique case (fit_mode_i)
      FIT_BEST:  take = hit && fits && (!found_q || (ctl_i.size < size_q));
      FIT_WORST: take = hit && (!found_q || (ctl_i.size > size_q));
      default:   take = hit && fits && !found_q;
    endcase
  end

  always_comb begin
    found_d = found_q;
    idx_d   = idx_q;
    size_d  = size_q;
    if (ctl_i.clr) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
      idx_d   = ctl_i.idx;
      size_d  = ctl_i.size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    size_q <= size_d;
  end

  assign pick_o.found = found_q;
  assign pick_o.idx   = idx_q;
  assign pick_o.size  = size_q;

endmodule

[src/hole_fit_allocator.sv]
// ----------------------------------------------------------------------------
// hole_fit_allocator
// Places process requests into a table of memory holes by first, best or
// worst fit and reports internal and external fragmentation totals.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Loads and
// restarts return their result in the cycle after acceptance. A placement
// walks the hole table one entry per cycle through the single read port of
// the size memory; busy stays high until the last entry is folded in, and
// the result strobe rises in the cycle in which busy falls.
// Results appear for a single cycle on done_o and cannot be held off; the
// totals ports hold their value until the next transaction changes them.
// No clearing pass follows reset: unwritten table entries are never read.
module hole_fit_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type_i,
  input  logic [hfa_pkg::SIZE_BITS-1:0] size_i,
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output logic [hfa_pkg::IDX_W-1:0]     hole_index_o,
  output logic [hfa_pkg::SIZE_BITS-1:0] leftover_o,
  output logic [hfa_pkg::TOTAL_W-1:0]   internal_total_o,
  output logic [hfa_pkg::TOTAL_W-1:0]   external_total_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hfa_pkg::APB_AW-1:0]    paddr,
  input  logic [hfa_pkg::APB_DW-1:0]    pwdata,
  output logic [hfa_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import hfa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                 state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     issue_q, issue_d;
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [SIZE_BITS-1:0] req_q, req_d;
  logic [MAX_HOLES-1:0] used_q, used_d;
  logic [TOTAL_W-1:0]   internal_q, internal_d;
  logic [TOTAL_W-1:0]   free_q, free_d;
  logic [TOTAL_W-1:0]   loaded_q, loaded_d;

  logic                 done_q, done_d;
  logic [2:0]           status_q, status_d;
  logic [IDX_W-1:0]     index_q, index_d;
  logic [SIZE_BITS-1:0] left_q, left_d;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [SIZE_BITS-1:0] mem_q [MAX_HOLES];
  logic [SIZE_BITS-1:0] mem_rdata_q;

  logic                 accept;
  logic                 issue_more;
  logic                 placed;
  logic [1:0]           fit_mode;
  scan_ctl_t            scan_ctl;
  pick_t                pick;

  hfa_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fit_mode_o (fit_mode)
  );

  assign accept     = start && !busy;
  assign issue_more = issue_q < count_q;

  assign scan_ctl.clr  = accept && (req_type_i == REQ_PLACE);
  assign scan_ctl.vld  = rd_vld_q;
  assign scan_ctl.free = !used_q[rd_idx_q];
  assign scan_ctl.idx  = rd_idx_q;
  assign scan_ctl.size = mem_rdata_q;

  hfa_picker u_picker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fit_mode_i (fit_mode),
    .req_size_i (req_q),
    .ctl_i      (scan_ctl),
    .pick_o     (pick)
  );

  // Worst fit may hold a candidate that is too small
  assign placed = pick.found && (pick.size >= req_q);

  assign mem_we    = accept && (req_type_i == REQ_LOAD) && (count_q != CNT_W'(MAX_HOLES));
  assign mem_waddr = count_q[IDX_W-1:0];
  assign mem_re    = (state_q == S_SCAN) && issue_more;
  assign mem_raddr = issue_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= size_i;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    issue_d    = issue_q;
    req_d      = req_q;
    used_d     = used_q;
    internal_d = internal_q;
    free_d     = free_q;
    loaded_d   = loaded_q;
    done_d     = 1'b0;
    status_d   = status_q;
    index_d    = index_q;
    left_d     = left_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = size_i;
          unique case (req_type_i)
            REQ_LOAD: begin
              done_d = 1'b1;
              left_d = '0;
              if (count_q == CNT_W'(MAX_HOLES)) begin
                status_d = STAT_FULL;
                index_d  = '0;
              end else begin
                status_d           = STAT_STORED;
                index_d            = count_q[IDX_W-1:0];
                used_d[mem_waddr]  = 1'b0;
                count_d            = count_q + CNT_W'(1);
                free_d             = free_q + TOTAL_W'(size_i);
                loaded_d           = loaded_q + TOTAL_W'(size_i);
              end
            end
            REQ_PLACE: begin
              state_d = S_SCAN;
              issue_d = '0;
            end
            REQ_RESTART: begin
              done_d     = 1'b1;
              status_d   = STAT_RESTART;
              index_d    = '0;
              left_d     = '0;
              used_d     = '0;
              internal_d = '0;
              free_d     = loaded_q;
            end
            default: begin
              // drop the transaction: no result
            end
          endcase
        end
      end
      S_SCAN: begin
        if (issue_more) begin
          issue_d = issue_q + CNT_W'(1);
        end else if (!rd_vld_q) begin
          // last entry folded in: commit the choice
          state_d = S_IDLE;
          done_d  = 1'b1;
          if (placed) begin
            status_d         = STAT_PLACED;
            index_d          = pick.idx;
            left_d           = pick.size - req_q;
            used_d[pick.idx] = 1'b1;
            internal_d       = internal_q + TOTAL_W'(pick.size - req_q);
            free_d           = free_q - TOTAL_W'(pick.size);
          end else begin
            status_d = STAT_NO_FIT;
            index_d  = '0;
            left_d   = '0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      issue_q    <= '0;
      rd_vld_q   <= 1'b0;
      used_q     <= '0;
      internal_q <= '0;
      free_q     <= '0;
      loaded_q   <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      issue_q    <= issue_d;
      rd_vld_q   <= mem_re;
      used_q     <= used_d;
      internal_q <= internal_d;
      free_q     <= free_d;
      loaded_q   <= loaded_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    rd_idx_q <= mem_raddr;
    status_q <= status_d;
    index_q  <= index_d;
    left_q   <= left_d;
  end

  assign busy             = (state_q == S_SCAN);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign hole_index_o     = index_q;
  assign leftover_o       = left_q;
  assign internal_total_o = internal_q;
  assign external_total_o = free_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a placement is still scanning");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_HOLES))
    else $error("hole count beyond table depth");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == REQ_LOAD || req_type_i == REQ_PLACE ||
                req_type_i == REQ_RESTART)) |=> (done_o || busy))
    else $error("accepted transaction neither answered nor in progress");

  a_leftover_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_PLACED) |-> (leftover_o == '0))
    else $error("nonzero leftover on a result that placed nothing");

endmodule
